FILE: rtl/ordered_list_engine_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define OLE_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define OLE_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;
  localparam int CAPACITY = 32;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_APPEND = 4'd0;
  localparam logic [3:0] OP_PREPEND = 4'd1;
  localparam logic [3:0] OP_INS_IDX = 4'd2;
  localparam logic [3:0] OP_INS_MATCH = 4'd3;
  localparam logic [3:0] OP_FIND = 4'd4;
  localparam logic [3:0] OP_READ = 4'd5;
  localparam logic [3:0] OP_DEL_IDX = 4'd6;
  localparam logic [3:0] OP_DEL_MATCH = 4'd7;
  localparam logic [3:0] OP_REPL = 4'd8;
  localparam logic [3:0] OP_WRITE = 4'd9;
  localparam logic [3:0] OP_CLEAR = 4'd10;
  localparam logic [3:0] OP_DUMP_F = 4'd11;
  localparam logic [3:0] OP_DUMP_R = 4'd12;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [2:0] {
    CC_HOLD, CC_INS, CC_SHL, CC_WRITE, CC_REPL
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_REPEAT, S_DELM, S_DUMP, S_OUT
  } state_t;
endpackage

FILE: rtl/ole_if.sv
// ----------------------------------------------------------------------------
// ole_in_if / ole_out_if
// Valid/ready channels for list commands and results.
// ----------------------------------------------------------------------------
interface ole_in_if;
  logic valid;
  logic ready;
  logic [3:0] op;
  logic [5:0] position;
  logic signed [31:0] key;
  logic signed [31:0] item_value;
  logic [5:0] repeat_count;
  modport source(output valid, op, position, key, item_value, repeat_count, input ready);
  modport sink(input valid, op, position, key, item_value, repeat_count, output ready);
endinterface

interface ole_out_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [31:0] data;
  logic [4:0] where;
  logic [5:0] count;
  logic [1:0] status;
  logic last;
  modport source(output valid, found, data, where, count, status, last, input ready);
  modport sink(input valid, found, data, where, count, status, last, output ready);
endinterface

FILE: rtl/ordered_list_engine_unit.sv
// An accepted item is decoded in the scan state, where a simple operation
// registers its result. Append, prepend and insert at index then pass through
// the repeat state, which inserts the copies, and match scans and delete-all step
// through the elements of the list. A dump gives one result per cycle while the sink is ready.
// One item is worked at a time: the next is taken only after the last result is accepted.
// Synchronous reset empties the list; cell contents are not reset.
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit
  import ole_pkg::*;
(
  input logic clk,
  input logic rst,
  ole_in_if.sink in_ch,
  ole_out_if.source out_ch
);
  // The cells form the store; cell i holds element i.
  logic signed [31:0] cv [CAPACITY];
  logic [CAPACITY-1:0] hits;
  cell_ctl_t ctl;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] lft, rgt;
    if (g == 0) begin : g_l
      assign lft = '0;
    end else begin : g_l
      assign lft = cv[g-1];
    end
    if (g == CAPACITY - 1) begin : g_r
      assign rgt = '0;
    end else begin : g_r
      assign rgt = cv[g+1];
    end
    ole_cell u_cell (
      .clk(clk), .idx(CW'(g)), .ctl(ctl), .left(lft), .right(rgt), .value(cv[g]),
      .hit(hits[g])
    );
  end

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [3:0] op;
  logic [CW-1:0] pos, pos_next;    // scan / insert / dump index
  logic signed [31:0] key, val;
  logic [5:0] reps, reps_next;     // copies left, or results sent in a dump
  logic hitflag, hitflag_next;
  // Output register.
  logic o_valid, o_valid_next, o_found, o_found_next, o_last, o_last_next;
  logic signed [31:0] o_data, o_data_next;
  logic [4:0] o_where, o_where_next;
  logic [1:0] o_status, o_status_next;

  logic take;
  logic o_free;
  assign o_free = !o_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && o_free;
  assign take = in_ch.valid && in_ch.ready;

  assign out_ch.valid = o_valid;
  assign out_ch.found = o_found;
  assign out_ch.data = o_data;
  assign out_ch.where = o_where;
  assign out_ch.count = 6'(cnt);
  assign out_ch.status = o_status;
  assign out_ch.last = o_last;

  logic [IW-1:0] pidx;
  assign pidx = pos[IW-1:0];
  logic scan_hit;
  assign scan_hit = (pos < cnt) && hits[pidx];

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pos_next = pos;
    reps_next = reps;
    hitflag_next = hitflag;
    o_valid_next = o_valid && !out_ch.ready;
    o_found_next = o_found;
    o_data_next = o_data;
    o_where_next = o_where;
    o_status_next = o_status;
    o_last_next = o_last;
    ctl = '{cmd: CC_HOLD, lo: '0, hi: '0, key: key, value: val};
    case (state)
      S_IDLE: if (take) begin
        // Operations are decoded from the registered copy next cycle.
        state_next = S_SCAN;
        pos_next = '0;
        hitflag_next = 1'b0;
        reps_next = in_ch.repeat_count;
        if (in_ch.op == OP_DUMP_F || in_ch.op == OP_DUMP_R) reps_next = '0;
        if (in_ch.op == OP_DUMP_R) pos_next = cnt - CW'(1);
        else if (in_ch.op == OP_READ || in_ch.op == OP_DEL_IDX ||
                 in_ch.op == OP_WRITE || in_ch.op == OP_INS_IDX)
          pos_next = CW'(in_ch.position);
      end
      S_SCAN: begin
        // Default single result.
        o_found_next = 1'b0; o_data_next = '0; o_where_next = '0;
        o_status_next = ST_OK; o_last_next = 1'b1;
        state_next = S_OUT;
        case (op)
          OP_APPEND, OP_PREPEND: begin
            if (cnt >= CW'(CAPACITY)) o_status_next = ST_FULL;
            else begin
              // One copy inserted at the tail or at the head.
              state_next = S_REPEAT; reps_next = 6'd1;
              pos_next = (op == OP_APPEND) ? cnt : '0;
            end
          end
          OP_INS_IDX: begin
            if (reps == 6'd0 || pos > cnt) o_status_next = ST_IGNORED;
            else state_next = S_REPEAT;
          end
          OP_INS_MATCH, OP_FIND, OP_DEL_MATCH, OP_REPL: begin
            if (op == OP_REPL) begin
              // All matches replaced at once; hit vector gives status.
              ctl.cmd = CC_REPL; ctl.lo = '0; ctl.hi = cnt;
              o_status_next = ST_IGNORED;
              for (int i = 0; i < CAPACITY; i++)
                if (hits[i] && CW'(i) < cnt) o_status_next = ST_OK;
            end else if (op == OP_DEL_MATCH) begin
              state_next = S_DELM;
            end else if (pos >= cnt) begin
              o_status_next = ST_IGNORED;
            end else if (hits[pidx]) begin
              if (op == OP_FIND) begin
                o_found_next = 1'b1; o_data_next = cv[pidx]; o_where_next = pidx;
              end else if (cnt >= CW'(CAPACITY)) o_status_next = ST_FULL;
              else begin
                state_next = S_REPEAT; reps_next = 6'd1;
              end
            end else begin
              pos_next = pos + CW'(1);
              state_next = S_SCAN;
            end
          end
          OP_READ: begin
            if (pos >= cnt) o_status_next = ST_IGNORED;
            else begin
              o_found_next = 1'b1; o_data_next = cv[pidx]; o_where_next = pidx;
            end
          end
          OP_DEL_IDX: begin
            if (pos >= cnt) o_status_next = ST_IGNORED;
            else begin
              ctl.cmd = CC_SHL; ctl.lo = pos; ctl.hi = cnt; cnt_next = cnt - CW'(1);
            end
          end
          OP_WRITE: begin
            if (pos >= cnt) o_status_next = ST_IGNORED;
            else begin
              ctl.cmd = CC_WRITE; ctl.lo = pos;
            end
          end
          OP_CLEAR: cnt_next = '0;
          OP_DUMP_F, OP_DUMP_R: if (cnt != '0) state_next = S_DUMP;
          default: o_status_next = ST_IGNORED;
        endcase
        if (state_next == S_OUT) o_valid_next = 1'b1;
      end
      S_REPEAT: begin
        // Insert one copy at pos per cycle: the cell at pos takes the value and
        // the cells above it move up by one.
        if (reps == 6'd0) begin
          o_valid_next = 1'b1; o_found_next = 1'b0; o_data_next = '0;
          o_where_next = '0; o_status_next = ST_OK; o_last_next = 1'b1;
          state_next = S_OUT;
        end else if (cnt >= CW'(CAPACITY)) begin
          o_valid_next = 1'b1; o_found_next = 1'b0; o_data_next = '0;
          o_where_next = '0; o_status_next = ST_FULL; o_last_next = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.cmd = CC_INS; ctl.lo = pos; ctl.hi = cnt + CW'(1);
          cnt_next = cnt + CW'(1);
          reps_next = reps - 6'd1;
          state_next = S_REPEAT;
        end
      end
      S_DELM: begin
        // A match is removed and the next element moves into its place, so the
        // index advances only past elements that stay.
        if (scan_hit) begin
          ctl.cmd = CC_SHL; ctl.lo = pos; ctl.hi = cnt;
          cnt_next = cnt - CW'(1); hitflag_next = 1'b1;
        end else if (pos < cnt) pos_next = pos + CW'(1);
        else begin
          o_valid_next = 1'b1; o_found_next = 1'b0; o_data_next = '0;
          o_where_next = '0; o_last_next = 1'b1;
          o_status_next = hitflag ? ST_OK : ST_IGNORED;
          state_next = S_OUT;
        end
      end
      S_DUMP: if (o_free) begin
        o_valid_next = 1'b1; o_found_next = 1'b1; o_data_next = cv[pidx];
        o_where_next = pidx; o_status_next = ST_OK;
        reps_next = reps + 6'd1;
        o_last_next = (reps + 6'd1 == 6'(cnt));
        pos_next = (op == OP_DUMP_F) ? pos + CW'(1) : pos - CW'(1);
        if (o_last_next) state_next = S_OUT;
      end
      S_OUT: if (o_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      o_valid <= o_valid_next;
    end
    pos <= pos_next;
    reps <= reps_next;
    hitflag <= hitflag_next;
    o_found <= o_found_next;
    o_data <= o_data_next;
    o_where <= o_where_next;
    o_status <= o_status_next;
    o_last <= o_last_next;
    if (take) begin
      op <= in_ch.op; key <= in_ch.key; val <= in_ch.item_value;
    end
  end
endmodule

FILE: rtl/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One list position: holds a value, shifts with its neighbors, compares key.
// ----------------------------------------------------------------------------
module ole_cell
  import ole_pkg::*;
(
  input  logic clk,
  input  logic [CW-1:0] idx,
  input  cell_ctl_t ctl,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  output logic signed [31:0] value,
  output logic hit
);
  logic in_rng;
  assign in_rng = (idx >= ctl.lo) && (idx < ctl.hi);
  assign hit = (value == ctl.key);

  // An insert loads the cell at lo and moves the cells above it up by one.
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CC_INS: begin
        if (in_rng) begin
          if (idx == ctl.lo) value <= ctl.value;
          else value <= left;
        end
      end
      CC_SHL: if (in_rng) value <= right;
      CC_WRITE: if (idx == ctl.lo) value <= ctl.value;
      CC_REPL: if (in_rng && hit) value <= ctl.value;
      default: ;
    endcase
  end
endmodule

FILE: rtl/ole_checker.sv
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks on the list engine.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_unit_defines.svh"
module ole_checker
  import ole_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid, in_ready, out_valid, out_ready,
  input logic [5:0] count,
  input logic [1:0] status,
  input logic found
);
  `OLE_ASSERT_IMP(a_cnt, clk, rst, 1'b1, count <= 6'(CAPACITY), "count beyond capacity")
  `OLE_ASSERT_IMP(a_st, clk, rst, out_valid, status <= ST_FULL, "bad status code")
  `OLE_ASSERT_IMP(a_fnd, clk, rst, out_valid && found, status == ST_OK, "found with error")
  `OLE_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `OLE_ASSERT_NXT(a_one, clk, rst, in_valid && in_ready, !in_ready, "second item taken")
endmodule

bind ordered_list_engine_unit ole_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .count(out_ch.count),
  .status(out_ch.status), .found(out_ch.found)
);
